[hdl/rar_pkg.sv]
// Package for the rational arithmetic reducer: payload types, codes and widths.
package rar_pkg;

  localparam int OPW = 16;
  localparam int MW  = 2 * OPW;

  typedef enum logic [1:0] {
    FN_ADD = 2'd0,
    FN_SUB = 2'd1,
    FN_MUL = 2'd2,
    FN_DIV = 2'd3
  } func_t;

  typedef struct packed {
    logic [1:0]            func;
    logic signed [OPW-1:0] a_num;
    logic [OPW-2:0]        a_den;
    logic signed [OPW-1:0] b_num;
    logic [OPW-2:0]        b_den;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] res_num;
    logic [30:0]        res_den;
    logic               status;
  } out_item_t;

  // Classified job handed from the front part to the back part.
  typedef struct packed {
    logic          neg;
    logic          err;
    logic          zero;
    logic [MW-1:0] nm;
    logic [MW-1:0] dm;
  } job_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GCD,
    ST_DIVN,
    ST_DIVD,
    ST_OUT
  } bst_t;

endpackage

[hdl/rar_front.sv]
// Front part: forms cross products and classifies each item into a job.
module rar_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rar_pkg::in_item_t  in_data,
  output logic               job_valid,
  input  logic               job_stall,
  output rar_pkg::job_t      job_data
);

  localparam int W = rar_pkg::OPW;
  localparam int M = rar_pkg::MW;

  // Stage one registers the signs and products; stage two combines them.
  logic          s1_v_r, s1_v_nxt;
  logic [1:0]    s1_f_r;
  logic          s1_sa_r, s1_sb_r;
  logic [M-1:0]  s1_p_r, s1_q_r, s1_d_r;
  logic          s2_v_r, s2_v_nxt;
  rar_pkg::job_t s2_r, s2_nxt;

  logic         sa, sb;
  logic [W-1:0] ma, mb;
  logic [M-1:0] p, q, d;
  logic         s1_adv, s2_adv;

  always_comb begin
    sa = in_data.a_num[W-1];
    sb = in_data.b_num[W-1];
    ma = sa ? W'(-in_data.a_num) : W'(in_data.a_num);
    mb = sb ? W'(-in_data.b_num) : W'(in_data.b_num);
    p  = M'(ma) * M'(in_data.b_den);
    d  = M'(in_data.a_den) * M'(in_data.b_den);
    q  = M'(mb) * M'(in_data.a_den);
    if (in_data.func == rar_pkg::FN_MUL) begin
      p = M'(ma) * M'(mb);
    end else if (in_data.func == rar_pkg::FN_DIV) begin
      d = M'(in_data.a_den) * M'(mb);
    end
  end

  assign s2_adv   = !s2_v_r || !job_stall;
  assign s1_adv   = !s1_v_r || s2_adv;
  assign in_stall = !s1_adv;

  always_comb begin
    logic sq;
    sq = (s1_f_r == rar_pkg::FN_SUB) ? !s1_sb_r : s1_sb_r;
    s2_nxt.dm  = s1_d_r;
    s2_nxt.err = (s1_d_r == '0);
    if (s1_f_r == rar_pkg::FN_ADD || s1_f_r == rar_pkg::FN_SUB) begin
      if (s1_sa_r == sq) begin
        s2_nxt.nm  = s1_p_r + s1_q_r;
        s2_nxt.neg = s1_sa_r;
      end else if (s1_p_r >= s1_q_r) begin
        s2_nxt.nm  = s1_p_r - s1_q_r;
        s2_nxt.neg = s1_sa_r;
      end else begin
        s2_nxt.nm  = s1_q_r - s1_p_r;
        s2_nxt.neg = sq;
      end
    end else begin
      s2_nxt.nm  = s1_p_r;
      s2_nxt.neg = s1_sa_r ^ s1_sb_r;
    end
    s2_nxt.zero = (s2_nxt.nm == '0);
  end

  assign s1_v_nxt = s1_adv ? in_valid : s1_v_r;
  assign s2_v_nxt = s2_adv ? s1_v_r : s2_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
    end
    if (s1_adv && in_valid) begin
      s1_f_r  <= in_data.func;
      s1_sa_r <= sa;
      s1_sb_r <= sb;
      s1_p_r  <= p;
      s1_q_r  <= q;
      s1_d_r  <= d;
    end
    if (s2_adv && s1_v_r) begin
      s2_r <= s2_nxt;
    end
  end

  assign job_valid = s2_v_r;
  assign job_data  = s2_r;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r && job_stall |=> s2_v_r && $stable(s2_r))
    else $error("front job changed while stalled");
  a_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> s1_v_r)
    else $error("accepted item lost in front stage");
  a_err: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r |-> s2_r.err == (s2_r.dm == '0))
    else $error("error class mismatch");

endmodule

[hdl/rar_queue.sv]
// Two-entry job queue between the front part and the back part.
module rar_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_valid,
  output logic          wr_stall,
  input  rar_pkg::job_t wr_data,
  output logic          rd_valid,
  input  logic          rd_stall,
  output rar_pkg::job_t rd_data
);

  rar_pkg::job_t mem_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       wr_go, rd_go;

  assign wr_stall = (cnt_r == 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign wr_go    = wr_valid && !wr_stall;
  assign rd_go    = rd_valid && !rd_stall;
  assign wp_nxt   = wr_go ? !wp_r : wp_r;
  assign rp_nxt   = rd_go ? !rp_r : rp_r;
  assign cnt_nxt  = cnt_r + 2'(wr_go) - 2'(rd_go);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (wr_go) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  a_cnt: assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("queue count out of range");
  a_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd1) |-> (wp_r != rp_r))
    else $error("queue pointers disagree with count");
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2) |-> (wp_r == rp_r))
    else $error("full queue pointers disagree");

endmodule

[hdl/rar_back.sv]
// Back part: binary GCD, two restoring divisions and the result register.
module rar_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               job_valid,
  output logic               job_stall,
  input  rar_pkg::job_t      job_data,
  output logic               out_valid,
  input  logic               out_stall,
  output rar_pkg::out_item_t out_data
);

  localparam int M  = rar_pkg::MW;
  localparam int CW = $clog2(M + 1);

  rar_pkg::bst_t st_r, st_nxt;
  logic [M-1:0]  x_r, x_nxt, y_r, y_nxt;     // GCD operands
  logic [CW-1:0] k_r, k_nxt;                 // common power of two
  logic [M-1:0]  nm_r, nm_nxt, dm_r, dm_nxt;
  logic          neg_r, neg_nxt;
  logic [M-1:0]  quo_r, quo_nxt, rem_r, rem_nxt;
  logic [CW-1:0] bit_r, bit_nxt;
  logic [M-1:0]  g_r, g_nxt;
  logic [M-1:0]  nq_r, nq_nxt;
  rar_pkg::out_item_t res_r, res_nxt;
  logic [M:0]    trial;
  logic [M-1:0]  rsh;
  logic [M-1:0]  dq;

  assign job_stall = (st_r != rar_pkg::ST_IDLE);
  assign out_valid = (st_r == rar_pkg::ST_OUT);
  assign out_data  = res_r;
  assign rsh   = {rem_r[M-2:0], quo_r[M-1]};
  assign trial = {1'b0, rsh} - {1'b0, g_r};
  assign dq    = {quo_r[M-2:0], !trial[M]};

  always_comb begin
    st_nxt = st_r; x_nxt = x_r; y_nxt = y_r; k_nxt = k_r;
    nm_nxt = nm_r; dm_nxt = dm_r; neg_nxt = neg_r;
    quo_nxt = quo_r; rem_nxt = rem_r; bit_nxt = bit_r;
    g_nxt = g_r; nq_nxt = nq_r; res_nxt = res_r;
    case (st_r)
      rar_pkg::ST_IDLE: begin
        if (job_valid) begin
          nm_nxt = job_data.nm; dm_nxt = job_data.dm; neg_nxt = job_data.neg;
          x_nxt = job_data.nm; y_nxt = job_data.dm; k_nxt = '0;
          if (job_data.err) begin
            res_nxt = '{res_num: '0, res_den: '0, status: 1'b1};
            st_nxt  = rar_pkg::ST_OUT;
          end else if (job_data.zero) begin
            res_nxt = '{res_num: '0, res_den: 31'd1, status: 1'b0};
            st_nxt  = rar_pkg::ST_OUT;
          end else begin
            st_nxt = rar_pkg::ST_GCD;
          end
        end
      end
      rar_pkg::ST_GCD: begin
        // Stein's algorithm: one shift, or one subtract and shift, per cycle.
        if (x_r == y_r) begin
          g_nxt   = x_r << k_r;
          quo_nxt = nm_r; rem_nxt = '0; bit_nxt = '0;
          st_nxt  = rar_pkg::ST_DIVN;
        end else if (!x_r[0] && !y_r[0]) begin
          x_nxt = x_r >> 1; y_nxt = y_r >> 1; k_nxt = k_r + 1'b1;
        end else if (!x_r[0]) begin
          x_nxt = x_r >> 1;
        end else if (!y_r[0]) begin
          y_nxt = y_r >> 1;
        end else if (x_r > y_r) begin
          x_nxt = (x_r - y_r) >> 1;
        end else begin
          y_nxt = (y_r - x_r) >> 1;
        end
      end
      rar_pkg::ST_DIVN, rar_pkg::ST_DIVD: begin
        rem_nxt = trial[M] ? rsh : trial[M-1:0];
        quo_nxt = dq;
        bit_nxt = bit_r + 1'b1;
        if (bit_r == CW'(M - 1)) begin
          bit_nxt = '0;
          if (st_r == rar_pkg::ST_DIVN) begin
            nq_nxt = dq; quo_nxt = dm_r; rem_nxt = '0;
            st_nxt = rar_pkg::ST_DIVD;
          end else begin
            res_nxt.res_num = neg_r ? 32'(-nq_r) : 32'(nq_r);
            res_nxt.res_den = 31'(dq);
            res_nxt.status  = 1'b0;
            st_nxt = rar_pkg::ST_OUT;
          end
        end
      end
      rar_pkg::ST_OUT: begin
        if (!out_stall) st_nxt = rar_pkg::ST_IDLE;
      end
      default: st_nxt = rar_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= rar_pkg::ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
    x_r <= x_nxt; y_r <= y_nxt; k_r <= k_nxt;
    nm_r <= nm_nxt; dm_r <= dm_nxt; neg_r <= neg_nxt;
    quo_r <= quo_nxt; rem_r <= rem_nxt; bit_r <= bit_nxt;
    g_r <= g_nxt; nq_r <= nq_nxt; res_r <= res_nxt;
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(res_r))
    else $error("result changed while stalled");
  a_gcd: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == rar_pkg::ST_GCD |-> x_r != '0 && y_r != '0)
    else $error("GCD operand reached zero");
  a_take: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == rar_pkg::ST_IDLE && job_valid |=> st_r != rar_pkg::ST_IDLE)
    else $error("job accepted but not started");

endmodule

[hdl/rational_arith_reduce.sv]
// Top level of the rational arithmetic reducer.
// Usage: an item on in_data (func, a_num/a_den, b_num/b_den) is taken at a
// rising edge with in_valid high and in_stall low. One result item per input
// item appears on out_data (res_num, res_den, status) with out_valid, and is
// taken when out_stall is low. Results keep input order.
// Path: an item passes the front stages and the queue, then the back part: a
// binary GCD (one shift or subtract per step) followed by two 32-bit
// restoring divisions, which the back part runs on one item at a time.
// Throughput is set by the single shared divide and GCD datapath in the back
// part; zero results and division by a zero fraction skip the GCD and divisions.
// A two-entry queue lets the front take new items while the back works.
// A synchronous active-low reset empties all stages and the queue.
// While out_stall is high the result holds steady and the back part waits;
// the front fills the queue and its own stages until full, then raises in_stall.
module rational_arith_reduce (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rar_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output rar_pkg::out_item_t out_data
);

  logic          fq_valid, fq_stall, qb_valid, qb_stall;
  rar_pkg::job_t fq_data, qb_data;

  rar_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .job_valid(fq_valid), .job_stall(fq_stall), .job_data(fq_data)
  );

  rar_queue u_queue (
    .clk, .rst_n,
    .wr_valid(fq_valid), .wr_stall(fq_stall), .wr_data(fq_data),
    .rd_valid(qb_valid), .rd_stall(qb_stall), .rd_data(qb_data)
  );

  rar_back u_back (
    .clk, .rst_n,
    .job_valid(qb_valid), .job_stall(qb_stall), .job_data(qb_data),
    .out_valid, .out_stall, .out_data
  );

endmodule

[test/tb_top.sv]
// Self-checking testbench for the rational arithmetic reducer.
`timescale 1ns / 100ps

module tb_top;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  rar_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  rar_pkg::out_item_t out_data;

  rar_pkg::in_item_t  pending_items[$];
  rar_pkg::out_item_t expected_results[$];
  int        fail_count = 0;
  bit        stimulus_done = 1'b0;
  bit        quiet_mode = 1'b0;
  bit        hold_off = 1'b0;
  int        send_gap = 0;
  int        recv_gap = 0;

  rational_arith_reduce DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #5 clk = ~clk;

  function automatic longint unsigned gcd_of(longint unsigned x, longint unsigned y);
    longint unsigned t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  // Works out the reduced fraction for one item.
  function automatic rar_pkg::out_item_t reduce_fraction(rar_pkg::in_item_t it);
    rar_pkg::out_item_t r;
    bit sa, sb, sq, sn;
    longint unsigned ma, mb, ad, bd, p, q, nm, dm, g, n, d;
    sa = it.a_num[rar_pkg::OPW-1];
    sb = it.b_num[rar_pkg::OPW-1];
    ma = sa ? -longint'(it.a_num) : longint'(it.a_num);
    mb = sb ? -longint'(it.b_num) : longint'(it.b_num);
    ad = it.a_den;
    bd = it.b_den;
    case (rar_pkg::func_t'(it.func))
      rar_pkg::FN_ADD, rar_pkg::FN_SUB: begin
        p = ma * bd;
        q = mb * ad;
        sq = (rar_pkg::func_t'(it.func) == rar_pkg::FN_SUB) ? !sb : sb;
        if (sa == sq) begin
          nm = p + q;
          sn = sa;
        end else if (p >= q) begin
          nm = p - q;
          sn = sa;
        end else begin
          nm = q - p;
          sn = sq;
        end
        dm = ad * bd;
      end
      rar_pkg::FN_MUL: begin
        nm = ma * mb;
        sn = sa != sb;
        dm = ad * bd;
      end
      default: begin
        nm = ma * bd;
        dm = ad * mb;
        sn = sa != sb;
      end
    endcase
    r = '0;
    if (dm == 0) begin
      r.status = 1'b1;
    end else if (nm == 0) begin
      r.res_den = 31'd1;
    end else begin
      g = gcd_of(nm, dm);
      n = nm / g;
      d = dm / g;
      r.res_num = sn ? -n[31:0] : n[31:0];
      r.res_den = d[30:0];
    end
    return r;
  endfunction

  function automatic rar_pkg::in_item_t make_item(rar_pkg::func_t f, int an, int adn,
                                                  int bn, int bdn);
    rar_pkg::in_item_t it;
    it.func  = f;
    it.a_num = an[rar_pkg::OPW-1:0];
    it.a_den = adn[rar_pkg::OPW-2:0];
    it.b_num = bn[rar_pkg::OPW-1:0];
    it.b_den = bdn[rar_pkg::OPW-2:0];
    return it;
  endfunction

  // Numerators are often small or share factors, so reduction does real work.
  function automatic rar_pkg::in_item_t random_item();
    rar_pkg::in_item_t it;
    int k;
    it = rar_pkg::in_item_t'({$urandom, $urandom});
    k = $urandom_range(0, 5);
    if (k == 0) begin
      it.a_num = $signed(16'($urandom_range(0, 40))) - 16'sd20;
      it.b_num = $signed(16'($urandom_range(0, 40))) - 16'sd20;
    end else if (k == 1) begin
      it.a_num = it.a_num & 16'hFF00;
      it.b_den = it.b_den & 15'h7F80;
    end else if (k == 2 && it.func == rar_pkg::FN_DIV) begin
      it.b_num = '0;
    end
    if (it.a_den == 0) it.a_den = 15'($urandom_range(1, 32767));
    if (it.b_den == 0) it.b_den = 15'($urandom_range(1, 32767));
    return it;
  endfunction

  // Driver: presents queued items, holding the payload while stalled.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(reduce_fraction(in_data));
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0 && !hold_off) begin
          in_data <= pending_items.pop_front();
          in_valid <= 1'b1;
          if (!quiet_mode && $urandom_range(0, 9) == 0) send_gap <= $urandom_range(1, 17);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks accepted results and stalls in random bursts.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_data);
          fail_count++;
        end else begin
          rar_pkg::out_item_t e;
          e = expected_results.pop_front();
          if (out_data.res_num !== e.res_num)
            $display("%0t: res_num expected %0d actual %0d", $time, e.res_num,
                     out_data.res_num);
          if (out_data.res_den !== e.res_den)
            $display("%0t: res_den expected %0d actual %0d", $time, e.res_den,
                     out_data.res_den);
          if (out_data.status !== e.status)
            $display("%0t: status expected %0b actual %0b", $time, e.status,
                     out_data.status);
          if (out_data !== e) fail_count++;
        end
      end
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_stall <= 1'b1;
      end else if (!quiet_mode && $urandom_range(0, 11) == 0) begin
        recv_gap <= $urandom_range(0, 16);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    int lim[6];
    lim = '{-32768, 32767, -1, 0, 1, 12345};
    foreach (lim[i]) begin
      pending_items.push_back(make_item(rar_pkg::func_t'(i % 4), lim[i], 32767,
                                        lim[5 - i], 1));
    end
    pending_items.push_back(make_item(rar_pkg::FN_ADD, 1, 2, -1, 2));
    pending_items.push_back(make_item(rar_pkg::FN_SUB, 3, 4, 3, 4));
    pending_items.push_back(make_item(rar_pkg::FN_MUL, -6, 8, 4, 9));
    pending_items.push_back(make_item(rar_pkg::FN_DIV, 5, 7, 0, 3));
    pending_items.push_back(make_item(rar_pkg::FN_DIV, -5, 7, 0, 32767));
    pending_items.push_back(make_item(rar_pkg::FN_DIV, 3, 5, -9, 10));
    pending_items.push_back(make_item(rar_pkg::FN_DIV, -32768, 1, -32768, 1));
    pending_items.push_back(make_item(rar_pkg::FN_MUL, -32768, 1, -32768, 1));
    pending_items.push_back(make_item(rar_pkg::FN_SUB, -32768, 1, 32767, 32767));
    pending_items.push_back(make_item(rar_pkg::FN_ADD, 32767, 32766, 32767, 32767));
    pending_items.push_back(make_item(rar_pkg::FN_MUL, 0, 5, -7, 3));
    pending_items.push_back(make_item(rar_pkg::FN_DIV, 21845, 10922, 10922, 21845));
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_items.size() == 0);
    // Let the pipeline drain completely before carrying on.
    hold_off = 1'b1;
    @(posedge clk);
    wait (!in_valid && expected_results.size() == 0);
    hold_off = 1'b0;
    repeat (1500) pending_items.push_back(random_item());
    wait (pending_items.size() == 0);
    quiet_mode = 1'b1;
    repeat (150) pending_items.push_back(random_item());
    wait (pending_items.size() == 0);
    @(posedge clk);
    while (in_valid) @(posedge clk);
    wait (expected_results.size() == 0);
    repeat (200) @(posedge clk);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
